### sv/aeske_pkg.sv
// shared types, constants and tables for the aes-128 key expansion block
// no dependencies; imported by every module of the block
package aeske_pkg;

   localparam int unsigned NUM_ROUND_KEYS = 11;
   localparam logic [3:0] FIRST_ROUND = 4'd0;
   localparam logic [3:0] LAST_ROUND  = 4'(NUM_ROUND_KEYS - 1);

   // input item: one master key as four words, byte 0 on top
   typedef struct packed {
      logic [31:0] key_word0;
      logic [31:0] key_word1;
      logic [31:0] key_word2;
      logic [31:0] key_word3;
   } req_type;

   // result item: one round key with its index
   typedef struct packed {
      logic [3:0]  round_index;
      logic [31:0] round_word0;
      logic [31:0] round_word1;
      logic [31:0] round_word2;
      logic [31:0] round_word3;
      logic        last_round;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       advance;
      logic [3:0] round;
   } cmd_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // round constant used when stepping from round r to round r+1
   function automatic logic [7:0] rcon(input logic [3:0] round);
      logic [7:0] value;
      unique case (round)
         4'd0:    value = 8'h01;
         4'd1:    value = 8'h02;
         4'd2:    value = 8'h04;
         4'd3:    value = 8'h08;
         4'd4:    value = 8'h10;
         4'd5:    value = 8'h20;
         4'd6:    value = 8'h40;
         4'd7:    value = 8'h80;
         4'd8:    value = 8'h1b;
         4'd9:    value = 8'h36;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

### sv/aes128_key_expansion.sv
// aes-128 key expansion: one master key in, eleven round keys out in order
// round key 0 is offered the cycle after the key item is accepted
// throughput: one round key per cycle while rsp_ready holds, set by the
// one-round-per-cycle schedule step; the next key enters with round key 10
// reset: synchronous active-high reset returns the controller to idle
module aes128_key_expansion
   import aeske_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type     cmd;
   logic [31:0] word0, word1, word2, word3;

   aeske_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   aeske_datapath u_datapath (
      .clock (clock),
      .cmd   (cmd),
      .key   (req_data),
      .word0 (word0),
      .word1 (word1),
      .word2 (word2),
      .word3 (word3)
   );

   // result item assembly
   assign rsp_data.round_index = cmd.round;
   assign rsp_data.round_word0 = word0;
   assign rsp_data.round_word1 = word1;
   assign rsp_data.round_word2 = word2;
   assign rsp_data.round_word3 = word3;
   assign rsp_data.last_round  = (cmd.round == LAST_ROUND);

   // an accepted key starts at round key 0
   a_start_round: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid && rsp_data.round_index == FIRST_ROUND)
      else $error("round key 0 not offered after key accept");

   // round index steps by one on each delivered non-final item
   a_round_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_round
      |=> rsp_valid && rsp_data.round_index == $past(rsp_data.round_index) + 4'd1)
      else $error("round index did not advance");

   // a key is only taken mid-run as the last round key leaves
   a_ready_overlap: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_data.last_round && rsp_ready)
      else $error("key accepted while round keys remain");

endmodule

### sv/aeske_datapath.sv
// round key register and next-round key schedule logic
// depends on aeske_pkg for types, s-box and round constants
module aeske_datapath
   import aeske_pkg::*;
(
   input  logic        clock,
   input  cmd_type     cmd,
   input  req_type     key,
   output logic [31:0] word0,
   output logic [31:0] word1,
   output logic [31:0] word2,
   output logic [31:0] word3
);

   logic [31:0] w0_ff, w1_ff, w2_ff, w3_ff;
   logic [31:0] w0_in, w1_in, w2_in, w3_in;
   logic [31:0] rot;
   logic [31:0] temp;
   logic [31:0] n0, n1, n2, n3;

   // rotate, substitute and add the round constant
   assign rot  = {w3_ff[23:0], w3_ff[31:24]};
   assign temp = {SBOX[rot[31:24]] ^ rcon(cmd.round), SBOX[rot[23:16]],
                  SBOX[rot[15:8]], SBOX[rot[7:0]]};

   // xor chain across the four columns
   assign n0 = w0_ff ^ temp;
   assign n1 = w1_ff ^ n0;
   assign n2 = w2_ff ^ n1;
   assign n3 = w3_ff ^ n2;

   // register select: load new key, step one round, or hold
   always_comb begin
      w0_in = w0_ff;
      w1_in = w1_ff;
      w2_in = w2_ff;
      w3_in = w3_ff;
      priority if (cmd.load) begin
         w0_in = key.key_word0;
         w1_in = key.key_word1;
         w2_in = key.key_word2;
         w3_in = key.key_word3;
      end else if (cmd.advance) begin
         w0_in = n0;
         w1_in = n1;
         w2_in = n2;
         w3_in = n3;
      end else begin
         w0_in = w0_ff;
         w1_in = w1_ff;
         w2_in = w2_ff;
         w3_in = w3_ff;
      end
   end

   always_ff @(posedge clock) begin
      w0_ff <= w0_in;
      w1_ff <= w1_in;
      w2_ff <= w2_in;
      w3_ff <= w3_in;
   end

   assign word0 = w0_ff;
   assign word1 = w1_ff;
   assign word2 = w2_ff;
   assign word3 = w3_ff;

endmodule

### sv/aeske_controller.sv
// state machine sequencing key load and round key delivery
// depends on aeske_pkg for the command struct and round constants
module aeske_controller
   import aeske_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd
);

   typedef enum logic {
      IDLE,
      EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] round_ff, round_in;
   logic       accept;
   logic       deliver;
   logic       last;

   assign last    = (round_ff == LAST_ROUND);
   assign deliver = (state_ff == EMIT) && rsp_ready;
   // a new key may enter as the final round key leaves
   assign req_ready = (state_ff == IDLE) || (deliver && last);
   assign accept    = req_valid && req_ready;

   // next state and round counter
   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      priority if (accept) begin
         state_in = EMIT;
         round_in = FIRST_ROUND;
      end else if (deliver) begin
         if (last) begin
            state_in = IDLE;
         end else begin
            round_in = round_ff + 4'd1;
         end
      end else begin
         state_in = state_ff;
         round_in = round_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         round_ff <= FIRST_ROUND;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end

   // commands to the datapath
   assign cmd.load    = accept;
   assign cmd.advance = deliver && !last;
   assign cmd.round   = round_ff;
   assign rsp_valid   = (state_ff == EMIT);

endmodule

### tb/aes128_key_expansion_checker.sv
// result checker for aes128_key_expansion: predicts the eleven round keys of
// every accepted key item and compares each accepted round key in order
// depends on aeske_pkg for the item types
module aes128_key_expansion_checker
   import aeske_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      failures,
   output int      round_keys_owed
);

   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0] sbox_lut [256];
   rsp_type    round_keys_due [$];

   // multiply in gf(2^8) modulo x^8 + x^4 + x^3 + x + 1
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= x;
         x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
      end
      return p;
   endfunction

   // s-box from first principles: field inverse then the affine map
   initial begin
      logic [7:0] inv;
      logic [7:0] s;
      for (int v = 0; v < 256; v++) begin
         inv = 8'h01;
         for (int k = 0; k < 254; k++) inv = gf_mul(inv, 8'(v));
         s = inv ^ 8'h63;
         for (int n = 1; n <= 4; n++) s ^= 8'((inv << n) | (inv >> (8 - n)));
         sbox_lut[v] = s;
      end
   end

   // rotate one byte left and substitute every byte
   function automatic logic [31:0] rot_sub_word(input logic [31:0] w);
      logic [31:0] r;
      r = {w[23:0], w[31:24]};
      for (int b = 0; b < 4; b++) r[8*b +: 8] = sbox_lut[r[8*b +: 8]];
      return r;
   endfunction

   // expand one master key and queue its eleven round keys
   function automatic void expand_key(input req_type key);
      logic [31:0] w0, w1, w2, w3;
      logic [7:0]  rc;
      rsp_type     round_key;
      w0 = key.key_word0;
      w1 = key.key_word1;
      w2 = key.key_word2;
      w3 = key.key_word3;
      rc = 8'h01;
      for (int r = 0; r < NUM_ROUND_KEYS; r++) begin
         if (r != 0) begin
            w0 ^= rot_sub_word(w3) ^ {rc, 24'h000000};
            w1 ^= w0;
            w2 ^= w1;
            w3 ^= w2;
            rc = gf_mul(rc, 8'h02);
         end
         round_key.round_index = 4'(r);
         round_key.round_word0 = w0;
         round_key.round_word1 = w1;
         round_key.round_word2 = w2;
         round_key.round_word3 = w3;
         round_key.last_round  = (r == NUM_ROUND_KEYS - 1);
         round_keys_due.push_back(round_key);
      end
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endtask

   // round keys are checked before new expectations are queued
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         failures = 0;
         round_keys_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (round_keys_due.size() == 0) begin
               failures++;
               $display("%0t: round key expected none got %h", $time, rsp_data);
            end else begin
               due = round_keys_due.pop_front();
               check_field("round_index", 32'(due.round_index),
                           32'(rsp_data.round_index));
               check_field("round_word0", due.round_word0, rsp_data.round_word0);
               check_field("round_word1", due.round_word1, rsp_data.round_word1);
               check_field("round_word2", due.round_word2, rsp_data.round_word2);
               check_field("round_word3", due.round_word3, rsp_data.round_word3);
               check_field("last_round", 32'(due.last_round),
                           32'(rsp_data.last_round));
            end
         end
         if (req_valid && req_ready) expand_key(req_data);
      end
      round_keys_owed <= round_keys_due.size();
   end

endmodule

### tb/tb_aes128_key_expansion.sv
// testbench top for aes128_key_expansion: drives key items, stalls the
// round key channel at random and gives the verdict
// depends on aeske_pkg, aes128_key_expansion and aes128_key_expansion_checker
module tb_aes128_key_expansion;

   import aeske_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_RANDOM_KEYS = 260;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 24;

   localparam logic [127:0] DIRECTED_KEYS [13] = '{
      128'h00000000_00000000_00000000_00000000,
      128'hffffffff_ffffffff_ffffffff_ffffffff,
      128'h2b7e1516_28aed2a6_abf71588_09cf4f3c,
      128'h00010203_04050607_08090a0b_0c0d0e0f,
      128'haaaaaaaa_aaaaaaaa_aaaaaaaa_aaaaaaaa,
      128'h55555555_55555555_55555555_55555555,
      128'h00000000_00000000_00000000_ffffffff,
      128'hffffffff_ffffffff_ffffffff_00000000,
      128'h80000000_00000000_00000000_00000001,
      128'h01234567_89abcdef_fedcba98_76543210,
      128'h2b7e1516_28aed2a6_abf71588_09cf4f3c,
      128'h00000000_00000000_00000000_000000ff,
      128'h00000000_00000000_00000000_ff000000
   };

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      failures;
   int      round_keys_owed;
   logic    calm;
   int      quiet_cycles;

   aes128_key_expansion u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   aes128_key_expansion_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .failures        (failures),
      .round_keys_owed (round_keys_owed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // round key consumer stalls about one cycle in ten outside the calm stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 10);
      end
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item accepted for %0d cycles", $time, quiet_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // random key word, biased toward all-zero and all-one bytes
   function automatic logic [31:0] random_key_word();
      logic [31:0] w;
      case ($urandom_range(7))
         0: w = 32'h00000000;
         1: w = 32'hffffffff;
         2: begin
            for (int b = 0; b < 4; b++) w[8*b +: 8] = $urandom_range(1) ? 8'hff : 8'h00;
         end
         default: w = $urandom();
      endcase
      return w;
   endfunction

   // offer one key item, with an optional gap first, and wait for acceptance
   task automatic send_key(input req_type key, input bit hold_off);
      if (hold_off) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(15, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= key;
      do @(posedge clock); while (!req_ready);
   endtask

   // stimulus and verdict
   initial begin
      req_type key;
      bit      in_calm;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      calm         = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed keys: extremes, known vector, patterns, repeats
      foreach (DIRECTED_KEYS[i]) begin
         key = DIRECTED_KEYS[i];
         send_key(key, $urandom_range(99) < 10);
      end

      // random keys with a long stretch of no stalls on either side
      for (int n = 0; n < NUM_RANDOM_KEYS; n++) begin
         in_calm = (n >= 100) && (n < 160);
         calm <= in_calm;
         key.key_word0 = random_key_word();
         key.key_word1 = random_key_word();
         key.key_word2 = random_key_word();
         key.key_word3 = random_key_word();
         send_key(key, !in_calm && ($urandom_range(99) < 10));
      end
      req_valid <= 1'b0;
      calm      <= 1'b0;

      // drain the outstanding round keys, then watch for strays
      @(posedge clock);
      while (round_keys_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### files.f
sv/aeske_pkg.sv
sv/aeske_datapath.sv
sv/aeske_controller.sv
sv/aes128_key_expansion.sv
tb/aes128_key_expansion_checker.sv
tb/tb_aes128_key_expansion.sv
